@@ rtl/rrte_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RIP route table engine package
// Shared types, codes and defaults for the route table engine.
// ----------------------------------------------------------------------------
package rrte_pkg;

  localparam int TableDepthDef = 32;
  localparam int IfaceCountDef = 4;

  localparam logic [4:0]  InfinityReset = 5'd16;
  localparam logic [15:0] ExpireReset   = 16'd20;

  typedef enum logic [2:0] {
    OP_RIP    = 3'd0,
    OP_ADD    = 3'd1,
    OP_DOWN   = 3'd2,
    OP_UP     = 3'd3,
    OP_TICK   = 3'd4,
    OP_SWEEP  = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_CHANGED  = 2'd0,
    ST_NOCHANGE = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOMATCH  = 2'd3
  } status_e;

  typedef enum logic {
    CFG_INFINITY = 1'b0,
    CFG_EXPIRE   = 1'b1
  } cfg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_SCAN,
    S_APPEND,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [31:0] dest;
    logic [31:0] mask;
    logic [31:0] gw;
    logic [1:0]  iface;
    logic [4:0]  cost;
    logic [31:0] stamp;
  } entry_t;

  typedef struct packed {
    logic load;
    logic start;
    logic scan;
    logic append;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic go_scan;
    logic go_append;
    logic scan_done;
    logic need_append;
    logic out_free;
  } stat_t;

endpackage

@@ rtl/rrte_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RIP route table engine controller
// Sequences accept, table scan, append and result hand-off.
// ----------------------------------------------------------------------------
module rrte_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  rrte_pkg::stat_t stat_i,
  output rrte_pkg::cmd_t  cmd_o
);

  rrte_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rrte_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rrte_pkg::S_IDLE: begin
        if (in_valid_i) state_d = rrte_pkg::S_START;
      end
      rrte_pkg::S_START: begin
        if (stat_i.go_scan) state_d = rrte_pkg::S_SCAN;
        else if (stat_i.go_append) state_d = rrte_pkg::S_APPEND;
        else state_d = rrte_pkg::S_RESP;
      end
      rrte_pkg::S_SCAN: begin
        if (stat_i.scan_done) begin
          state_d = stat_i.need_append ? rrte_pkg::S_APPEND : rrte_pkg::S_RESP;
        end
      end
      rrte_pkg::S_APPEND: state_d = rrte_pkg::S_RESP;
      rrte_pkg::S_RESP: begin
        if (stat_i.out_free) state_d = rrte_pkg::S_IDLE;
      end
      default: state_d = rrte_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      rrte_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      rrte_pkg::S_START:  cmd_o.start  = 1'b1;
      rrte_pkg::S_SCAN:   cmd_o.scan   = 1'b1;
      rrte_pkg::S_APPEND: cmd_o.append = 1'b1;
      rrte_pkg::S_RESP:   cmd_o.emit   = stat_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

@@ rtl/rrte_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RIP route table engine datapath
// Route memory, slot evaluation, counters, config and result registers.
// ----------------------------------------------------------------------------
module rrte_dp #(
  parameter int TABLE_DEPTH = rrte_pkg::TableDepthDef,
  parameter int IFACE_COUNT = rrte_pkg::IfaceCountDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic            cfg_idx_i,
  input  logic [15:0]     cfg_wdata_i,
  input  logic [2:0]      opcode_i,
  input  logic [31:0]     route_address_i,
  input  logic [31:0]     route_mask_i,
  input  logic [31:0]     next_hop_ip_i,
  input  logic [31:0]     route_metric_i,
  input  logic [1:0]      iface_index_i,
  input  logic            last_of_packet_i,
  input  logic            out_ready_i,
  output logic            out_valid_o,
  output logic [1:0]      status_o,
  output logic            route_changed_o,
  output logic            send_update_o,
  output logic [5:0]      route_count_o,
  input  rrte_pkg::cmd_t  cmd_i,
  output rrte_pkg::stat_t stat_o
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DepthCnt = CNT_W'(TABLE_DEPTH);

  // item
  logic [2:0]  op_q;
  logic [31:0] addr_q, mask_q, hop_q, metric_q;
  logic [1:0]  ifc_q;
  logic        last_q;

  // config and global state
  logic [4:0]       inf_q;
  logic [15:0]      exp_q;
  logic [CNT_W-1:0] used_q;
  logic [31:0]      now_q;
  logic             dirty_q;

  // scan state
  logic [CNT_W-1:0] rd_idx_q;
  logic [IDX_W-1:0] ev_idx_q;
  logic             pend_q;
  logic             found_q, any_q, changed_q, full_q;
  rrte_pkg::entry_t rdata_q;
  rrte_pkg::entry_t mem [TABLE_DEPTH];

  // result
  logic       out_valid_q;
  logic [1:0] status_q;
  logic       chg_out_q, send_q;
  logic [5:0] count_q;

  logic        ifc_ok, metric_inf, has_room;
  logic [4:0]  new_m, add_m, one_m;
  logic [31:0] net, key, age;
  logic        match, stop, issue;
  logic        ev_hit, ev_any, ev_chg, ev_we;
  rrte_pkg::entry_t ev_entry, wdata;
  logic             we;
  logic [IDX_W-1:0] waddr;
  logic [1:0]       status_d;
  logic             dirty_d, send_d;

  assign ifc_ok     = (32'(ifc_q) < IFACE_COUNT);
  assign metric_inf = (metric_q == {27'd0, inf_q});
  assign new_m      = (metric_q >= {27'd0, inf_q}) ? inf_q : metric_q[4:0] + 5'd1;
  assign add_m      = (metric_q > {27'd0, inf_q}) ? inf_q : metric_q[4:0];
  assign one_m      = (inf_q == 5'd0) ? 5'd0 : 5'd1;
  assign net        = addr_q & mask_q;
  assign key        = (op_q == rrte_pkg::OP_UP) ? net : addr_q;
  assign match      = (rdata_q.dest == key);
  assign age        = now_q - rdata_q.stamp;
  assign has_room   = (used_q < DepthCnt);

  // evaluate the slot whose read data just arrived
  always_comb begin
    ev_entry = rdata_q;
    ev_hit   = 1'b0;
    ev_any   = 1'b0;
    ev_chg   = 1'b0;
    ev_we    = 1'b0;
    if (pend_q) begin
      case (op_q)
        rrte_pkg::OP_RIP: begin
          if (match) begin
            ev_hit = 1'b1;
            if (rdata_q.cost == inf_q ||
                (hop_q != rdata_q.gw &&
                 (rdata_q.cost > new_m || (rdata_q.cost == 5'd0 && rdata_q.gw != 32'd0)))) begin
              ev_entry.gw    = hop_q;
              ev_entry.mask  = mask_q;
              ev_entry.iface = ifc_q;
              ev_entry.cost  = new_m;
              ev_entry.stamp = now_q;
              ev_chg = 1'b1;
              ev_we  = 1'b1;
            end else if (hop_q == rdata_q.gw) begin
              if (rdata_q.cost > new_m) begin
                ev_entry.cost = new_m;
                ev_chg = 1'b1;
              end
              ev_entry.stamp = now_q;
              ev_we = 1'b1;
            end
          end
        end
        rrte_pkg::OP_DOWN: begin
          if (rdata_q.iface == ifc_q) begin
            ev_any = 1'b1;
            if (rdata_q.cost != inf_q) begin
              ev_entry.cost = inf_q;
              ev_chg = 1'b1;
              ev_we  = 1'b1;
            end
          end
        end
        rrte_pkg::OP_UP: begin
          if (match) begin
            ev_hit = 1'b1;
            ev_entry.stamp = now_q;
            ev_we = 1'b1;
          end
        end
        rrte_pkg::OP_SWEEP: begin
          if (age >= {16'd0, exp_q} && rdata_q.cost != inf_q) begin
            ev_entry.cost = inf_q;
            ev_chg = 1'b1;
            ev_we  = 1'b1;
          end
        end
        default: ev_we = 1'b0;
      endcase
    end
  end

  // first match ends the search for rip entries and interface up
  assign stop  = ev_hit;
  assign issue = cmd_i.scan && !stop && (rd_idx_q < used_q);

  assign stat_o.go_scan = ((op_q == rrte_pkg::OP_RIP) && ifc_ok && !metric_inf) ||
                          ((op_q == rrte_pkg::OP_DOWN || op_q == rrte_pkg::OP_UP) && ifc_ok) ||
                          (op_q == rrte_pkg::OP_SWEEP);
  assign stat_o.go_append   = (op_q == rrte_pkg::OP_ADD) && ifc_ok;
  assign stat_o.scan_done   = stop || (!pend_q && rd_idx_q >= used_q);
  assign stat_o.need_append = (op_q == rrte_pkg::OP_UP) && !(found_q || stop);
  assign stat_o.out_free    = !out_valid_q || out_ready_i;

  // single write port: slot update during scan, or append
  always_comb begin
    we    = 1'b0;
    waddr = ev_idx_q;
    wdata = ev_entry;
    if (cmd_i.append) begin
      we    = has_room;
      waddr = used_q[IDX_W-1:0];
      if (op_q == rrte_pkg::OP_ADD) begin
        wdata = '{dest: addr_q, mask: mask_q, gw: hop_q, iface: ifc_q,
                  cost: add_m, stamp: now_q};
      end else begin
        wdata = '{dest: net, mask: mask_q, gw: 32'd0, iface: ifc_q,
                  cost: one_m, stamp: now_q};
      end
    end else if (cmd_i.scan) begin
      we = ev_we;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[rd_idx_q[IDX_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q     <= opcode_i;
      addr_q   <= route_address_i;
      mask_q   <= route_mask_i;
      hop_q    <= next_hop_ip_i;
      metric_q <= route_metric_i;
      ifc_q    <= iface_index_i;
      last_q   <= last_of_packet_i;
    end
    if (issue) ev_idx_q <= rd_idx_q[IDX_W-1:0];
  end

  always_comb begin
    status_d = rrte_pkg::ST_NOCHANGE;
    case (op_q)
      rrte_pkg::OP_RIP: begin
        if (ifc_ok && !metric_inf) begin
          if (!found_q) status_d = rrte_pkg::ST_NOMATCH;
          else if (changed_q) status_d = rrte_pkg::ST_CHANGED;
        end
      end
      rrte_pkg::OP_ADD: begin
        if (ifc_ok) status_d = full_q ? rrte_pkg::ST_FULL : rrte_pkg::ST_CHANGED;
      end
      rrte_pkg::OP_DOWN: begin
        if (ifc_ok) begin
          if (!any_q) status_d = rrte_pkg::ST_NOMATCH;
          else if (changed_q) status_d = rrte_pkg::ST_CHANGED;
        end
      end
      rrte_pkg::OP_UP: begin
        if (ifc_ok && !found_q) status_d = full_q ? rrte_pkg::ST_FULL : rrte_pkg::ST_CHANGED;
      end
      rrte_pkg::OP_SWEEP: begin
        if (changed_q) status_d = rrte_pkg::ST_CHANGED;
      end
      default: status_d = rrte_pkg::ST_NOCHANGE;
    endcase
  end

  assign dirty_d = dirty_q || changed_q;
  assign send_d  = (op_q == rrte_pkg::OP_SWEEP) ||
                   ((op_q == rrte_pkg::OP_RIP) && last_q && dirty_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inf_q       <= rrte_pkg::InfinityReset;
      exp_q       <= rrte_pkg::ExpireReset;
      used_q      <= '0;
      now_q       <= '0;
      dirty_q     <= 1'b0;
      rd_idx_q    <= '0;
      pend_q      <= 1'b0;
      found_q     <= 1'b0;
      any_q       <= 1'b0;
      changed_q   <= 1'b0;
      full_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          rrte_pkg::CFG_INFINITY: inf_q <= cfg_wdata_i[4:0];
          rrte_pkg::CFG_EXPIRE:   exp_q <= cfg_wdata_i;
          default: inf_q <= inf_q;
        endcase
      end
      if (cmd_i.start) begin
        rd_idx_q  <= '0;
        pend_q    <= 1'b0;
        found_q   <= 1'b0;
        any_q     <= 1'b0;
        changed_q <= 1'b0;
        full_q    <= 1'b0;
      end
      if (cmd_i.scan) begin
        pend_q <= issue;
        if (issue) rd_idx_q <= rd_idx_q + 1'b1;
        found_q   <= found_q | ev_hit;
        any_q     <= any_q | ev_any;
        changed_q <= changed_q | ev_chg;
      end
      if (cmd_i.append) begin
        full_q    <= !has_room;
        changed_q <= has_room;
        if (has_room) used_q <= used_q + 1'b1;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
        if (op_q == rrte_pkg::OP_TICK) now_q <= now_q + 32'd1;
        if (op_q == rrte_pkg::OP_RIP) dirty_q <= last_q ? 1'b0 : dirty_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      status_q  <= status_d;
      chg_out_q <= changed_q;
      send_q    <= send_d;
      count_q   <= 6'(used_q);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign route_changed_o = chg_out_q;
  assign send_update_o   = send_q;
  assign route_count_o   = count_q;

endmodule

@@ rtl/rip_route_table_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RIP route table engine
// Distance-vector route table with append, poison, refresh and aging.
// ----------------------------------------------------------------------------
// One item is handled at a time. Tick, unused opcodes, rip entries at
// infinity and items on a bad interface go from accept straight to the result;
// add route goes through an append step first. Rip entry, interface down/up
// and sweep walk the table one slot per cycle through the route memory, which
// has one read and one write port, and interface up appends when no slot
// matched; a rip entry or interface up stops the walk at its first match.
// A result waits in an output register until the receiver takes it; the engine
// is ready for the next item in the cycle after the result is loaded into it.
module rip_route_table_engine #(
  parameter int TABLE_DEPTH = rrte_pkg::TableDepthDef,
  parameter int IFACE_COUNT = rrte_pkg::IfaceCountDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  opcode_i,
  input  logic [31:0] route_address_i,
  input  logic [31:0] route_mask_i,
  input  logic [31:0] next_hop_ip_i,
  input  logic [31:0] route_metric_i,
  input  logic [1:0]  iface_index_i,
  input  logic        last_of_packet_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic        route_changed_o,
  output logic        send_update_o,
  output logic [5:0]  route_count_o
);

  rrte_pkg::cmd_t  cmd;
  rrte_pkg::stat_t stat;

  rrte_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  rrte_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .IFACE_COUNT (IFACE_COUNT)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .opcode_i         (opcode_i),
    .route_address_i  (route_address_i),
    .route_mask_i     (route_mask_i),
    .next_hop_ip_i    (next_hop_ip_i),
    .route_metric_i   (route_metric_i),
    .iface_index_i    (iface_index_i),
    .last_of_packet_i (last_of_packet_i),
    .out_ready_i      (out_ready_i),
    .out_valid_o      (out_valid_o),
    .status_o         (status_o),
    .route_changed_o  (route_changed_o),
    .send_update_o    (send_update_o),
    .route_count_o    (route_count_o),
    .cmd_i            (cmd),
    .stat_o           (stat)
  );

`ifndef NO_ASSERTIONS
  // busy right after an accepted beat
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("engine ready again right after accept");

  // a changed route always reports the changed status
  a_changed_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && route_changed_o |-> status_o == rrte_pkg::ST_CHANGED)
    else $error("route_changed without changed status");

  // the route count only holds or grows by one
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && $past(out_valid_o) && $past(rst_ni) |->
      route_count_o == $past(route_count_o) ||
      route_count_o == 6'($past(route_count_o) + 6'd1))
    else $error("route count jumped");
`endif

endmodule

@@ tb/rrte_route_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RIP route table checker
// Watches the config port and both channels of the route table engine, keeps
// its own copy of the route table, predicts one reply per accepted item and
// compares each accepted reply field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module rrte_route_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [2:0]  opcode_i,
  input  logic [31:0] route_address_i,
  input  logic [31:0] route_mask_i,
  input  logic [31:0] next_hop_ip_i,
  input  logic [31:0] route_metric_i,
  input  logic [1:0]  iface_index_i,
  input  logic        last_of_packet_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [1:0]  status_i,
  input  logic        route_changed_i,
  input  logic        send_update_i,
  input  logic [5:0]  route_count_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  localparam int Depth = rrte_pkg::TableDepthDef;

  typedef struct {
    rrte_pkg::status_e status;
    logic              changed;
    logic              send;
    logic [5:0]        count;
  } reply_t;

  logic [31:0] tbl_dest  [Depth];
  logic [31:0] tbl_mask  [Depth];
  logic [31:0] tbl_gw    [Depth];
  logic [1:0]  tbl_iface [Depth];
  logic [4:0]  tbl_cost  [Depth];
  logic [31:0] tbl_stamp [Depth];
  logic [5:0]  n_routes;
  logic [31:0] now_sec;
  logic        pkt_dirty;
  logic [4:0]  inf_cost;
  logic [15:0] expire_age;

  reply_t expected_replies[$];

  function automatic logic [4:0] clamp_cost(logic [32:0] m);
    return (m > {28'd0, inf_cost}) ? inf_cost : m[4:0];
  endfunction

  task automatic add_route(input logic [31:0] d, input logic [31:0] m, input logic [31:0] g,
                           input logic [1:0] ifc, input logic [4:0] c, output logic ok);
    ok = 1'b0;
    if (n_routes < Depth) begin
      tbl_dest[n_routes]  = d;
      tbl_mask[n_routes]  = m;
      tbl_gw[n_routes]    = g;
      tbl_iface[n_routes] = ifc;
      tbl_cost[n_routes]  = c;
      tbl_stamp[n_routes] = now_sec;
      n_routes = n_routes + 6'd1;
      ok = 1'b1;
    end
  endtask

  task automatic take_path(input int k, input logic [31:0] m, input logic [31:0] g,
                           input logic [1:0] ifc, input logic [4:0] c);
    tbl_gw[k]    = g;
    tbl_mask[k]  = m;
    tbl_iface[k] = ifc;
    tbl_cost[k]  = c;
    tbl_stamp[k] = now_sec;
  endtask

  task automatic apply_route_op(output reply_t r);
    logic [4:0]  m;
    logic [31:0] net;
    logic        found;
    logic        ok;
    logic        any;
    int          k;
    r.status  = rrte_pkg::ST_NOCHANGE;
    r.changed = 1'b0;
    r.send    = 1'b0;
    found     = 1'b0;
    any       = 1'b0;
    k         = 0;
    case (opcode_i)
      rrte_pkg::OP_RIP: begin
        if (route_metric_i != {27'd0, inf_cost}) begin
          m = clamp_cost({1'b0, route_metric_i} + 33'd1);
          for (k = 0; k < n_routes; k++)
            if (tbl_dest[k] == route_address_i) begin
              found = 1'b1;
              break;
            end
          if (!found) begin
            r.status = rrte_pkg::ST_NOMATCH;
          end else if (tbl_cost[k] == inf_cost) begin
            take_path(k, route_mask_i, next_hop_ip_i, iface_index_i, m);
            r.changed = 1'b1;
          end else if (next_hop_ip_i == tbl_gw[k]) begin
            if (tbl_cost[k] > m) begin
              tbl_cost[k] = m;
              r.changed = 1'b1;
            end
            tbl_stamp[k] = now_sec;
          end else if (tbl_cost[k] > m || (tbl_cost[k] == 0 && tbl_gw[k] != 0)) begin
            take_path(k, route_mask_i, next_hop_ip_i, iface_index_i, m);
            r.changed = 1'b1;
          end
          if (r.changed) r.status = rrte_pkg::ST_CHANGED;
        end
        if (r.changed) pkt_dirty = 1'b1;
        if (last_of_packet_i) begin
          r.send    = pkt_dirty;
          pkt_dirty = 1'b0;
        end
      end
      rrte_pkg::OP_ADD: begin
        add_route(route_address_i, route_mask_i, next_hop_ip_i, iface_index_i,
                  clamp_cost({1'b0, route_metric_i}), ok);
        if (ok) begin
          r.status  = rrte_pkg::ST_CHANGED;
          r.changed = 1'b1;
        end else begin
          r.status = rrte_pkg::ST_FULL;
        end
      end
      rrte_pkg::OP_DOWN: begin
        for (k = 0; k < n_routes; k++)
          if (tbl_iface[k] == iface_index_i) begin
            any = 1'b1;
            if (tbl_cost[k] != inf_cost) begin
              tbl_cost[k] = inf_cost;
              r.changed = 1'b1;
            end
          end
        r.status = !any ? rrte_pkg::ST_NOMATCH :
                   (r.changed ? rrte_pkg::ST_CHANGED : rrte_pkg::ST_NOCHANGE);
      end
      rrte_pkg::OP_UP: begin
        net = route_address_i & route_mask_i;
        for (k = 0; k < n_routes; k++)
          if (tbl_dest[k] == net) begin
            tbl_stamp[k] = now_sec;
            found = 1'b1;
            break;
          end
        if (!found) begin
          add_route(net, route_mask_i, 32'd0, iface_index_i, clamp_cost(33'd1), ok);
          if (ok) begin
            r.status  = rrte_pkg::ST_CHANGED;
            r.changed = 1'b1;
          end else begin
            r.status = rrte_pkg::ST_FULL;
          end
        end
      end
      rrte_pkg::OP_TICK: now_sec = now_sec + 32'd1;
      rrte_pkg::OP_SWEEP: begin
        for (k = 0; k < n_routes; k++)
          if ((now_sec - tbl_stamp[k]) >= {16'd0, expire_age} && tbl_cost[k] != inf_cost) begin
            tbl_cost[k] = inf_cost;
            r.changed = 1'b1;
          end
        r.status = r.changed ? rrte_pkg::ST_CHANGED : rrte_pkg::ST_NOCHANGE;
        r.send   = 1'b1;
      end
      default: ;
    endcase
    r.count = n_routes;
  endtask

  always @(posedge clk_i) begin
    reply_t got;
    reply_t want;
    if (!rst_ni) begin
      n_routes     = '0;
      now_sec      = '0;
      pkt_dirty    = 1'b0;
      inf_cost     = rrte_pkg::InfinityReset;
      expire_age   = rrte_pkg::ExpireReset;
      fail_count_o = 0;
      expected_replies.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == rrte_pkg::CFG_INFINITY) inf_cost = cfg_wdata_i[4:0];
        else expire_age = cfg_wdata_i;
      end
      // retire the reply first: it always belongs to an earlier beat
      if (out_valid_i && out_ready_i) begin
        if (expected_replies.size() == 0) begin
          $display("%0t: reply with nothing expected: status %0d changed %0b send %0b count %0d",
                   $time, status_i, route_changed_i, send_update_i, route_count_i);
          fail_count_o++;
        end else begin
          want = expected_replies.pop_front();
          if (status_i !== want.status || route_changed_i !== want.changed ||
              send_update_i !== want.send || route_count_i !== want.count) begin
            $display("%0t: expected status %0d changed %0b send %0b count %0d, got %0d %0b %0b %0d",
                     $time, want.status, want.changed, want.send, want.count,
                     status_i, route_changed_i, send_update_i, route_count_i);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        apply_route_op(got);
        expected_replies.push_back(got);
      end
    end
    pending_o = expected_replies.size();
  end

endmodule

@@ tb/tb_rip_route_table_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RIP route table engine testbench
// Drives directed and random route operations under several metric and
// aging settings and idle patterns; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_rip_route_table_engine;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_idx;
  logic [15:0] cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  opcode;
  logic [31:0] route_address;
  logic [31:0] route_mask;
  logic [31:0] next_hop_ip;
  logic [31:0] route_metric;
  logic [1:0]  iface_index;
  logic        last_of_packet;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  status;
  logic        route_changed;
  logic        send_update;
  logic [5:0]  route_count;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned tx_idle;
  int unsigned rx_idle;
  int unsigned sent_items;
  logic [4:0]  cur_inf;
  bit          hold_req;

  rip_route_table_engine i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .opcode_i        (opcode),
    .route_address_i (route_address),
    .route_mask_i    (route_mask),
    .next_hop_ip_i   (next_hop_ip),
    .route_metric_i  (route_metric),
    .iface_index_i   (iface_index),
    .last_of_packet_i(last_of_packet),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .status_o        (status),
    .route_changed_o (route_changed),
    .send_update_o   (send_update),
    .route_count_o   (route_count)
  );

  rrte_route_checker i_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .opcode_i        (opcode),
    .route_address_i (route_address),
    .route_mask_i    (route_mask),
    .next_hop_ip_i   (next_hop_ip),
    .route_metric_i  (route_metric),
    .iface_index_i   (iface_index),
    .last_of_packet_i(last_of_packet),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .status_i        (status),
    .route_changed_i (route_changed),
    .send_update_i   (send_update),
    .route_count_i   (route_count),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  initial begin
    #2_000_000;
    $display("rip_route_table_engine: mismatch");
    $finish;
  end

  // receiver: random ready, with one long hold-off on request
  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (400) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle);
      end
    end
  end

  // call at a negedge; returns at a negedge with valid still high
  task automatic send_item(input logic [2:0] op, input logic [31:0] addr,
                           input logic [31:0] mask, input logic [31:0] hop,
                           input logic [31:0] metric, input logic [1:0] ifc,
                           input logic last);
    while ($urandom_range(99) < tx_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    opcode         <= op;
    route_address  <= addr;
    route_mask     <= mask;
    next_hop_ip    <= hop;
    route_metric   <= metric;
    iface_index    <= ifc;
    last_of_packet <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    sent_items++;
  endtask

  task automatic drain_replies();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_config(input logic [4:0] inf, input logic [15:0] age);
    drain_replies();
    repeat (40) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= rrte_pkg::CFG_INFINITY;
    cfg_wdata <= {11'd0, inf};
    @(negedge clk);
    cfg_idx   <= rrte_pkg::CFG_EXPIRE;
    cfg_wdata <= age;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cur_inf = inf;
  endtask

  function automatic logic [31:0] pick_dest();
    if ($urandom_range(9) == 0) return $urandom;
    return 32'h0A00_0000 | ($urandom_range(0, 39) << 16);
  endfunction

  function automatic logic [31:0] pick_gw();
    int unsigned g;
    g = $urandom_range(0, 4);
    if ($urandom_range(99) < 15) return $urandom;
    return (g == 0) ? 32'd0 : (32'hC0A8_0000 | g);
  endfunction

  function automatic logic [31:0] pick_metric();
    int unsigned s;
    s = $urandom_range(99);
    if (s < 70) return $urandom_range(0, cur_inf + 1);
    if (s < 80) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  function automatic logic [31:0] pick_mask();
    return ($urandom_range(9) == 0) ? $urandom : 32'hFFFF_0000;
  endfunction

  task automatic run_random(input int unsigned n);
    int unsigned stop_at;
    int unsigned sel;
    int unsigned len;
    stop_at = sent_items + n;
    while (sent_items < stop_at) begin
      sel = $urandom_range(99);
      if (sel < 35) begin
        // well-formed packet of rip entries
        len = $urandom_range(1, 5);
        for (int i = 0; i < len; i++)
          send_item(rrte_pkg::OP_RIP, pick_dest(), pick_mask(), pick_gw(), pick_metric(),
                    2'($urandom_range(3)), i == len - 1);
      end else if (sel < 41) begin
        send_item(rrte_pkg::OP_ADD, pick_dest(), pick_mask(), pick_gw(), pick_metric(),
                  2'($urandom_range(3)), 1'($urandom_range(1)));
      end else if (sel < 45) begin
        send_item(rrte_pkg::OP_DOWN, $urandom, $urandom, $urandom, $urandom,
                  2'($urandom_range(3)), 1'($urandom_range(1)));
      end else if (sel < 51) begin
        send_item(rrte_pkg::OP_UP, pick_dest() | $urandom_range(16'hFFFF), pick_mask(),
                  $urandom, $urandom, 2'($urandom_range(3)), 1'($urandom_range(1)));
      end else if (sel < 76) begin
        send_item(rrte_pkg::OP_TICK, $urandom, $urandom, $urandom, $urandom,
                  2'($urandom_range(3)), 1'($urandom_range(1)));
      end else if (sel < 88) begin
        send_item(rrte_pkg::OP_SWEEP, $urandom, $urandom, $urandom, $urandom,
                  2'($urandom_range(3)), 1'($urandom_range(1)));
      end else if (sel < 91) begin
        send_item(3'($urandom_range(6, 7)), $urandom, $urandom, $urandom, $urandom,
                  2'($urandom_range(3)), 1'($urandom_range(1)));
      end else begin
        // broken packet: random end marker
        send_item(rrte_pkg::OP_RIP, pick_dest(), pick_mask(), pick_gw(), pick_metric(),
                  2'($urandom_range(3)), 1'($urandom_range(1)));
      end
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = rrte_pkg::CFG_INFINITY;
    cfg_wdata      = '0;
    in_valid       = 1'b0;
    opcode         = rrte_pkg::OP_TICK;
    route_address  = '0;
    route_mask     = '0;
    next_hop_ip    = '0;
    route_metric   = '0;
    iface_index    = '0;
    last_of_packet = 1'b0;
    hold_req       = 1'b0;
    sent_items     = 0;
    cur_inf        = rrte_pkg::InfinityReset;
    tx_idle        = 24;
    rx_idle        = 84;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    write_config(5'd16, 16'd20);
    // directed: empty table, adds, every rip rule, interfaces, aging
    send_item(rrte_pkg::OP_RIP, 32'h0A01_0000, 32'hFFFF_0000, 32'hC0A8_0001, 32'd3, 2'd0,
              1'b1);
    send_item(rrte_pkg::OP_DOWN, 32'd0, 32'd0, 32'd0, 32'd0, 2'd3, 1'b0);
    send_item(rrte_pkg::OP_ADD, 32'h0A01_0000, 32'hFFFF_0000, 32'hC0A8_0001, 32'd5, 2'd0,
              1'b0);
    send_item(rrte_pkg::OP_ADD, 32'h0A02_0000, 32'hFFFF_0000, 32'hC0A8_0002, 32'd0, 2'd1,
              1'b0);
    send_item(rrte_pkg::OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              2'd3, 1'b1);
    send_item(rrte_pkg::OP_ADD, 32'd0, 32'd0, 32'd0, 32'd0, 2'd2, 1'b0);
    send_item(rrte_pkg::OP_RIP, 32'h0A01_0000, 32'hFFFF_0000, 32'hC0A8_0009, 32'd16, 2'd0,
              1'b0);
    send_item(rrte_pkg::OP_RIP, 32'h0A01_0000, 32'hFFFF_0000, 32'hC0A8_0001, 32'd7, 2'd0,
              1'b0);
    send_item(rrte_pkg::OP_RIP, 32'h0A01_0000, 32'hFFFF_0000, 32'hC0A8_0001, 32'd1, 2'd0,
              1'b1);
    send_item(rrte_pkg::OP_RIP, 32'h0A01_0000, 32'hFFFF_0000, 32'hC0A8_0009, 32'd0, 2'd1,
              1'b1);
    send_item(rrte_pkg::OP_RIP, 32'h0A02_0000, 32'hFFFF_0000, 32'hC0A8_0007, 32'd9, 2'd2,
              1'b0);
    send_item(rrte_pkg::OP_RIP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF,
              2'd3, 1'b1);
    send_item(rrte_pkg::OP_RIP, 32'hFFFF_FFFF, 32'h0, 32'hC0A8_0003, 32'd2, 2'd1, 1'b1);
    send_item(rrte_pkg::OP_DOWN, 32'd0, 32'd0, 32'd0, 32'd0, 2'd1, 1'b0);
    send_item(rrte_pkg::OP_DOWN, 32'd0, 32'd0, 32'd0, 32'd0, 2'd1, 1'b0);
    send_item(rrte_pkg::OP_RIP, 32'h0A01_0000, 32'hFFFF_0000, 32'hC0A8_0004, 32'd4, 2'd2,
              1'b1);
    send_item(rrte_pkg::OP_UP, 32'h0A03_1234, 32'hFFFF_0000, 32'd0, 32'd0, 2'd2, 1'b0);
    send_item(rrte_pkg::OP_UP, 32'h0A03_5678, 32'hFFFF_0000, 32'd0, 32'd0, 2'd3, 1'b0);
    for (int i = 0; i < 21; i++)
      send_item(rrte_pkg::OP_TICK, 32'd0, 32'd0, 32'd0, 32'd0, 2'd0, 1'b0);
    send_item(rrte_pkg::OP_SWEEP, 32'd0, 32'd0, 32'd0, 32'd0, 2'd0, 1'b0);
    send_item(rrte_pkg::OP_SWEEP, 32'd0, 32'd0, 32'd0, 32'd0, 2'd0, 1'b0);
    send_item(3'd6, 32'd0, 32'd0, 32'd0, 32'd0, 2'd0, 1'b0);
    send_item(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd3, 1'b1);
    run_random(380);

    tx_idle = 84;
    rx_idle = 24;
    write_config(5'd1, 16'd1);
    run_random(300);

    tx_idle = 0;
    rx_idle = 0;
    write_config(5'd31, 16'hFFFF);
    run_random(150);
    // pause until every reply is back, then go on
    drain_replies();
    run_random(150);

    write_config(5'd5, 16'($urandom_range(1, 40)));
    hold_req = 1'b1;
    run_random(650);

    drain_replies();
    repeat (60) @(negedge clk);
    if (fail_count == 0) begin
      $display("rip_route_table_engine: match");
    end else begin
      $display("rip_route_table_engine: mismatch");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/rrte_pkg.sv
rtl/rrte_ctrl.sv
rtl/rrte_dp.sv
rtl/rip_route_table_engine.sv
tb/rrte_route_checker.sv
tb/tb_rip_route_table_engine.sv
